@@ rtl/core/mwf_pkg.sv @@
// Package for the maze wall follower: grid constants, codes, payload structs
// and the left-hand direction picker. It depends on nothing else.
package mwf_pkg;

    // Grid size in cells. The row and column fields cap the usable grid at 64 x 64.
    localparam int ROWS       = 64;
    localparam int COLS       = 64;
    localparam int N_ROWS     = (ROWS < 64) ? ROWS : 64;
    localparam int N_COLS     = (COLS < 64) ? COLS : 64;
    localparam int CELL_DEPTH = N_ROWS * N_COLS;
    localparam int ADDR_W     = $clog2(CELL_DEPTH);

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // Directions. The open and exit bits use the same order.
    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_STARTED = 3'd0,
        STAT_MOVED   = 3'd1,
        STAT_EXIT    = 3'd2,
        STAT_STUCK   = 3'd3,
        STAT_IDLE    = 3'd4
    } t_status;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    // Operation that issued the pending cell read.
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    // Incoming request payload.
    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic [3:0] open_sides;
        logic [3:0] exit_sides;
    } t_req;

    // Outgoing result payload.
    typedef struct packed {
        logic [5:0] pos_row;
        logic [5:0] pos_col;
        logic [1:0] heading;
        logic [2:0] status;
    } t_rsp;

    // Cell word: exit sides in the upper nibble, open sides in the lower.
    typedef logic [7:0] t_cell;

    // Command to the cell store.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        t_cell             wdata;
    } t_mem_cmd;

    // Linear cell address from row and column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [5:0] row,
                                                    input logic [5:0] col);
        logic [31:0] lin;
        lin = 32'(row) * 32'(N_COLS) + 32'(col);
        return lin[ADDR_W-1:0];
    endfunction

    // True when row and column lie inside the grid in use.
    function automatic logic in_grid(input logic [5:0] row, input logic [5:0] col);
        return (32'(row) < 32'(N_ROWS)) && (32'(col) < 32'(N_COLS));
    endfunction

    // Left-hand rule: try left of the heading, straight, right, then back.
    // Returns {found, direction}.
    function automatic logic [2:0] pick_dir(input logic [1:0] head,
                                            input logic [3:0] sides);
        logic [1:0] d;
        logic [2:0] res;
        res = '0;
        d   = '0;
        // Walk the order backwards so the earliest open choice wins.
        for (int k = 3; k >= 0; k--) begin
            d = head + 2'(k + 3);
            if (sides[d]) begin
                res = {1'b1, d};
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/core/mwf_cell_mem.sv @@
// Cell store of the maze wall follower: one synchronous memory with a single
// port and a registered read. It depends on mwf_pkg.
module mwf_cell_mem (
    input  logic              i_clk,
    input  mwf_pkg::t_mem_cmd i_cmd,
    output mwf_pkg::t_cell    o_rd_data
);
    import mwf_pkg::*;

    t_cell r_mem [CELL_DEPTH];
    t_cell r_rd_data;

    // Write port and registered read port share one address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.addr] <= i_cmd.wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/maze_wall_follower_unit.sv @@
// A load writes the cell store and gives no result. A start or step that reads
// the cell store goes through the read state and registers its result when the
// read word is taken; a step while idle, a stuck step or a start outside the grid
// registers its result from idle. One load, idle step or stuck step is taken per
// cycle while the result slot is free; no request is taken while a cell read is
// pending. Reset clears the walker to row 0, column 0, heading right, not running.
module maze_wall_follower_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  mwf_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_stall,
    output mwf_pkg::t_rsp o_res
);
    import mwf_pkg::*;

    t_state   r_state, n_state;
    logic [5:0] r_row, n_row;
    logic [5:0] r_col, n_col;
    logic [1:0] r_head, n_head;
    logic     r_running, n_running;
    t_cell    r_cur_cell, n_cur_cell;
    t_op      r_op, n_op;
    logic     r_res_valid, n_res_valid;
    t_rsp     r_res, n_res;
    logic     res_load;
    logic     slot_free;
    logic     accept;
    t_mem_cmd mem_cmd;
    t_cell    rd_data;
    logic [3:0] usable;
    logic [2:0] pick;
    logic [5:0] step_row;
    logic [5:0] step_col;

    // Cell store.
    mwf_cell_mem u_cell_mem (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .o_rd_data (rd_data)
    );

    // Handshake: a request enters only in idle and only when the result slot frees.
    assign slot_free   = !r_res_valid || !i_res_stall;
    assign accept      = (r_state == ST_IDLE) && i_req_valid && slot_free;
    assign o_req_stall = !((r_state == ST_IDLE) && slot_free);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Passages of the current cell, with those leaving the grid removed.
    always_comb begin
        usable = r_cur_cell[3:0];
        if (r_col == 6'd0) begin
            usable[DIR_LEFT] = 1'b0;
        end
        if (r_row == 6'd0) begin
            usable[DIR_UP] = 1'b0;
        end
        if (32'(r_col) + 32'd1 >= 32'(N_COLS)) begin
            usable[DIR_RIGHT] = 1'b0;
        end
        if (32'(r_row) + 32'd1 >= 32'(N_ROWS)) begin
            usable[DIR_DOWN] = 1'b0;
        end
    end

    // Chosen direction and the cell it leads to.
    always_comb begin
        pick     = pick_dir(r_head, usable);
        step_row = r_row;
        step_col = r_col;
        unique case (t_dir'(pick[1:0]))
            DIR_LEFT:  step_col = r_col - 6'd1;
            DIR_UP:    step_row = r_row - 6'd1;
            DIR_RIGHT: step_col = r_col + 6'd1;
            DIR_DOWN:  step_row = r_row + 6'd1;
            default:   step_row = r_row;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (t_kind'(i_req.kind) == KIND_START) &&
                    in_grid(i_req.cell_row, i_req.cell_col)) begin
                    n_state = ST_READ;
                end else if (accept && (t_kind'(i_req.kind) == KIND_STEP) &&
                             r_running && pick[2]) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory commands, walker updates and results.
    always_comb begin
        mem_cmd    = '0;
        n_row      = r_row;
        n_col      = r_col;
        n_head     = r_head;
        n_running  = r_running;
        n_cur_cell = r_cur_cell;
        n_op       = r_op;
        n_res      = r_res;
        res_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_kind'(i_req.kind))
                        KIND_LOAD: begin
                            if (in_grid(i_req.cell_row, i_req.cell_col)) begin
                                mem_cmd.wr_en = 1'b1;
                                mem_cmd.addr  = cell_addr(i_req.cell_row, i_req.cell_col);
                                mem_cmd.wdata = {i_req.exit_sides, i_req.open_sides};
                                // Keep the cached walker cell coherent with the store.
                                if ((i_req.cell_row == r_row) && (i_req.cell_col == r_col)) begin
                                    n_cur_cell = {i_req.exit_sides, i_req.open_sides};
                                end
                            end
                        end
                        KIND_START: begin
                            if (!in_grid(i_req.cell_row, i_req.cell_col)) begin
                                n_running = 1'b0;
                                res_load  = 1'b1;
                                n_res     = {r_row, r_col, r_head, STAT_IDLE};
                            end else begin
                                n_row         = i_req.cell_row;
                                n_col         = i_req.cell_col;
                                n_head        = DIR_RIGHT;
                                n_op          = OP_START;
                                mem_cmd.rd_en = 1'b1;
                                mem_cmd.addr  = cell_addr(i_req.cell_row, i_req.cell_col);
                            end
                        end
                        KIND_STEP: begin
                            if (!r_running) begin
                                res_load = 1'b1;
                                n_res    = {r_row, r_col, r_head, STAT_IDLE};
                            end else if (!pick[2]) begin
                                n_running = 1'b0;
                                res_load  = 1'b1;
                                n_res     = {r_row, r_col, r_head, STAT_STUCK};
                            end else begin
                                n_row         = step_row;
                                n_col         = step_col;
                                n_head        = pick[1:0];
                                n_op          = OP_STEP;
                                mem_cmd.rd_en = 1'b1;
                                mem_cmd.addr  = cell_addr(step_row, step_col);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                // The new cell word arrives: cache it and check its exit sides.
                if (slot_free) begin
                    n_cur_cell = rd_data;
                    res_load   = 1'b1;
                    if (rd_data[7:4] != 4'd0) begin
                        n_running = 1'b0;
                        n_res     = {r_row, r_col, r_head, STAT_EXIT};
                    end else begin
                        n_running = 1'b1;
                        n_res     = {r_row, r_col, r_head,
                                     (r_op == OP_START) ? STAT_STARTED : STAT_MOVED};
                    end
                end
            end
            default: ;
        endcase
    end

    // Result slot holds until taken.
    assign n_res_valid = res_load || (r_res_valid && i_res_stall);

    // Control and walker registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= 6'd0;
            r_col       <= 6'd0;
            r_head      <= DIR_RIGHT;
            r_running   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_head      <= n_head;
            r_running   <= n_running;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur_cell <= n_cur_cell;
        r_op       <= n_op;
        r_res      <= n_res;
    end

`ifndef NO_ASSERTIONS
    // A pending read that finds the slot free always completes with a result.
    a_read_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && slot_free) |=> (r_res_valid && r_state == ST_IDLE))
        else $error("cell read finished without a result");

    // A load never starts a memory read cycle.
    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_kind'(i_req.kind) == KIND_LOAD) |=> (r_state == ST_IDLE))
        else $error("load request left the idle state");

    // The single memory port never reads and writes at once.
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_cmd.wr_en && mem_cmd.rd_en))
        else $error("cell store read and written in the same cycle");

    // A walk that ended stays ended while its result is shown.
    a_walk_ended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && (r_res.status == STAT_STUCK || r_res.status == STAT_EXIT))
        |-> !r_running)
        else $error("walker still running after stuck or exit result");
`endif

endmodule

@@ sim/tb_maze_wall_follower_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for maze_wall_follower_unit: a directed walk through the
// corner cases, then random maze walks, checked against a built-in wall-follower predictor.
// Depends on mwf_pkg and the unit under test only.
module tb_maze_wall_follower_unit;
    import mwf_pkg::*;

    localparam int N_ITEMS     = 1850;
    localparam int CALM_ITEMS  = 200;
    localparam int CYCLE_LIMIT = 800000;
    localparam int BACKLOG_MAX = 8;
    // Two copies of the walker: one steers stimulus ahead of time, one checks results.
    localparam int GEN_VIEW    = 0;
    localparam int CHK_VIEW    = 1;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic i_res_stall = 1'b0;
    t_req i_req       = '0;
    logic o_req_stall;
    logic o_res_valid;
    t_rsp o_res;

    // Walker state and cell store, one copy per view.
    logic [7:0] cell_mem [2][CELL_DEPTH];
    bit         cell_set [2][CELL_DEPTH];
    logic [5:0] at_row   [2];
    logic [5:0] at_col   [2];
    logic [1:0] facing   [2];
    bit         walking  [2];

    t_req req_backlog [$];
    t_rsp due_reports [$];
    int   n_queued  = 0;
    int   n_taken   = 0;
    int   n_sent    = 0;
    int   n_results = 0;
    int   n_bad     = 0;
    int   n_cycles  = 0;
    int   send_gap  = 0;
    int   stall_gap = 0;
    bit   req_taken = 1'b0;
    bit   calm      = 1'b0;

    maze_wall_follower_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int cell_index(input logic [5:0] row, input logic [5:0] col);
        return int'(row) * N_COLS + int'(col);
    endfunction

    function automatic logic [11:0] neighbor(input logic [5:0] row, input logic [5:0] col,
                                             input logic [1:0] way);
        case (t_dir'(way))
            DIR_LEFT:  col = col - 6'd1;
            DIR_UP:    row = row - 6'd1;
            DIR_RIGHT: col = col + 6'd1;
            default:   row = row + 6'd1;
        endcase
        return {row, col};
    endfunction

    // Left-hand rule on the walker's cell; passages that leave the grid count as walls.
    function automatic bit choose_way(input int m, output logic [1:0] way);
        logic [3:0] sides;
        logic [1:0] d;
        sides = cell_mem[m][cell_index(at_row[m], at_col[m])][3:0];
        if (at_col[m] == 6'd0) sides[DIR_LEFT] = 1'b0;
        if (at_row[m] == 6'd0) sides[DIR_UP] = 1'b0;
        if (int'(at_col[m]) + 1 >= N_COLS) sides[DIR_RIGHT] = 1'b0;
        if (int'(at_row[m]) + 1 >= N_ROWS) sides[DIR_DOWN] = 1'b0;
        way = facing[m];
        // Left of the heading first, then straight, right and back.
        for (int k = 0; k < 4; k++) begin
            d = facing[m] + 2'(k + 3);
            if (sides[d]) begin
                way = d;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to a view of the walker; returns 1 when it yields a report.
    function automatic bit follow_wall(input int m, input t_req rq, output t_rsp rs);
        logic [1:0] way;
        t_status    st;
        int         idx;
        bit         on_grid;
        rs      = '0;
        st      = STAT_IDLE;
        idx     = cell_index(rq.cell_row, rq.cell_col);
        on_grid = int'(rq.cell_row) < N_ROWS && int'(rq.cell_col) < N_COLS;
        case (t_kind'(rq.kind))
            KIND_LOAD: begin
                if (on_grid) begin
                    cell_mem[m][idx] = {rq.exit_sides, rq.open_sides};
                    cell_set[m][idx] = 1'b1;
                end
                return 1'b0;
            end
            KIND_START: begin
                if (!on_grid) begin
                    walking[m] = 1'b0;
                end else begin
                    at_row[m]  = rq.cell_row;
                    at_col[m]  = rq.cell_col;
                    facing[m]  = DIR_RIGHT;
                    walking[m] = cell_mem[m][idx][7:4] == 4'd0;
                    st = walking[m] ? STAT_STARTED : STAT_EXIT;
                end
            end
            KIND_STEP: begin
                if (!walking[m]) begin
                    st = STAT_IDLE;
                end else if (!choose_way(m, way)) begin
                    walking[m] = 1'b0;
                    st = STAT_STUCK;
                end else begin
                    facing[m] = way;
                    {at_row[m], at_col[m]} = neighbor(at_row[m], at_col[m], way);
                    walking[m] = cell_mem[m][cell_index(at_row[m], at_col[m])][7:4] == 4'd0;
                    st = walking[m] ? STAT_MOVED : STAT_EXIT;
                end
            end
            default: return 1'b0;
        endcase
        rs.pos_row = at_row[m];
        rs.pos_col = at_col[m];
        rs.heading = facing[m];
        rs.status  = st;
        return 1'b1;
    endfunction

    function automatic t_req mk_req(input t_kind kind, input logic [5:0] row,
                                    input logic [5:0] col, input logic [3:0] open_sides,
                                    input logic [3:0] exit_sides);
        t_req rq;
        rq.kind       = kind;
        rq.cell_row   = row;
        rq.cell_col   = col;
        rq.open_sides = open_sides;
        rq.exit_sides = exit_sides;
        return rq;
    endfunction

    // Mostly open cells keep walks going; exits are rare so walks get long.
    function automatic logic [3:0] rand_open();
        if ($urandom_range(0, 3) == 0) return 4'($urandom);
        return 4'($urandom | $urandom);
    endfunction

    function automatic logic [3:0] rand_exit();
        if ($urandom_range(0, 11) == 0) return 4'($urandom_range(1, 15));
        return 4'd0;
    endfunction

    function automatic logic [5:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return 6'd0;
            1:       return 6'd63;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic note_fail(input string msg);
        n_bad++;
        if (n_bad <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // Queues one request, keeping the stimulus view of the walker in step.
    task automatic send(input t_req rq);
        t_rsp unused;
        void'(follow_wall(GEN_VIEW, rq, unused));
        while (req_backlog.size() >= BACKLOG_MAX) @(posedge i_clk);
        req_backlog = {req_backlog, rq};
        n_queued++;
        if (t_kind'(rq.kind) != KIND_NONE) n_sent++;
    endtask

    // A cell is loaded before anything can read it.
    task automatic ensure_loaded(input logic [5:0] row, input logic [5:0] col);
        if (!cell_set[GEN_VIEW][cell_index(row, col)])
            send(mk_req(KIND_LOAD, row, col, rand_open(), rand_exit()));
    endtask

    task automatic start_at(input logic [5:0] row, input logic [5:0] col, input bit fresh);
        if (fresh) send(mk_req(KIND_LOAD, row, col, rand_open(), rand_exit()));
        else ensure_loaded(row, col);
        send(mk_req(KIND_START, row, col, 4'($urandom), 4'($urandom)));
    endtask

    // A step request; the cell the walker will move into is loaded first.
    task automatic step_walker();
        logic [1:0]  way;
        logic [11:0] dest;
        if (walking[GEN_VIEW] && choose_way(GEN_VIEW, way)) begin
            dest = neighbor(at_row[GEN_VIEW], at_col[GEN_VIEW], way);
            ensure_loaded(dest[11:6], dest[5:0]);
        end
        send(mk_req(KIND_STEP, 6'($urandom), 6'($urandom), 4'($urandom), 4'($urandom)));
    endtask

    task automatic wait_drained();
        while (n_taken != n_queued || due_reports.size() != 0) @(negedge i_clk);
    endtask

    // Request driver: holds a stalled request, otherwise idles in bursts or sends the next.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (i_req_valid && !req_taken) begin
            i_req_valid <= 1'b1;
        end else if (send_gap != 0) begin
            send_gap    <= send_gap - 1;
            i_req_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap    <= $urandom_range(0, 15);
            i_req_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
            i_req       <= req_backlog.pop_front();
            i_req_valid <= 1'b1;
        end else begin
            i_req_valid <= 1'b0;
        end
    end

    // Result stall in random bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_res_stall <= 1'b0;
        end else if (stall_gap != 0) begin
            stall_gap   <= stall_gap - 1;
            i_res_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_gap   <= $urandom_range(0, 15);
            i_res_stall <= 1'b1;
        end else begin
            i_res_stall <= 1'b0;
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted result.
    always @(posedge i_clk) begin
        t_rsp calc;
        t_rsp want;
        if (i_rst_n) begin
            if (o_res_valid && !i_res_stall) begin
                n_results++;
                if (due_reports.size() == 0) begin
                    note_fail($sformatf("unexpected result row %0d col %0d heading %0d status %0d",
                                        o_res.pos_row, o_res.pos_col, o_res.heading,
                                        o_res.status));
                end else begin
                    want = due_reports.pop_front();
                    if (o_res.pos_row !== want.pos_row || o_res.pos_col !== want.pos_col ||
                        o_res.heading !== want.heading || o_res.status !== want.status)
                        note_fail($sformatf({"result %0d: expected row %0d col %0d heading %0d ",
                                             "status %0d, got row %0d col %0d heading %0d ",
                                             "status %0d"}, n_results,
                                            want.pos_row, want.pos_col, want.heading,
                                            want.status, o_res.pos_row, o_res.pos_col,
                                            o_res.heading, o_res.status));
                end
            end
            if (i_req_valid && !o_req_stall) begin
                n_taken++;
                if (follow_wall(CHK_VIEW, i_req, calc)) due_reports = {due_reports, calc};
            end
        end
        req_taken <= i_rst_n && i_req_valid && !o_req_stall;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_maze_wall_follower_unit: FAIL");
            $finish;
        end
    end

    initial begin
        int  steps;
        bit  paused;
        paused = 1'b0;
        for (int m = 0; m < 2; m++) begin
            at_row[m]  = 6'd0;
            at_col[m]  = 6'd0;
            facing[m]  = DIR_RIGHT;
            walking[m] = 1'b0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A step before any start reports idle; an unused kind is dropped.
        send(mk_req(KIND_STEP, 6'd63, 6'd63, 4'hF, 4'hF));
        send(mk_req(KIND_NONE, 6'd63, 6'd0, 4'hF, 4'h0));
        // Top-left corner: the off-grid sides are walls, and a dead end turns the walker back.
        send(mk_req(KIND_LOAD, 6'd0, 6'd0, 4'b1111, 4'd0));
        send(mk_req(KIND_LOAD, 6'd0, 6'd1, 4'b0001, 4'd0));
        send(mk_req(KIND_START, 6'd0, 6'd0, 4'd0, 4'd0));
        step_walker();
        step_walker();
        // Bottom-right corner: turn up into a closed cell, get stuck, then stay idle.
        send(mk_req(KIND_LOAD, 6'd63, 6'd63, 4'b1111, 4'd0));
        send(mk_req(KIND_LOAD, 6'd62, 6'd63, 4'b0000, 4'd0));
        send(mk_req(KIND_START, 6'd63, 6'd63, 4'hF, 4'hF));
        step_walker();
        step_walker();
        step_walker();
        // Bottom-left corner: straight ahead into an exit cell.
        send(mk_req(KIND_LOAD, 6'd63, 6'd0, 4'b1101, 4'd0));
        send(mk_req(KIND_LOAD, 6'd63, 6'd1, 4'b0000, 4'b1000));
        send(mk_req(KIND_START, 6'd63, 6'd0, 4'd0, 4'd0));
        step_walker();
        step_walker();
        // The entrance cell itself is an exit.
        send(mk_req(KIND_LOAD, 6'd32, 6'd32, 4'b0000, 4'b1111));
        send(mk_req(KIND_START, 6'd32, 6'd32, 4'd0, 4'd0));
        // Top-right corner: every open side points off the grid.
        send(mk_req(KIND_LOAD, 6'd0, 6'd63, 4'b0110, 4'd0));
        send(mk_req(KIND_START, 6'd0, 6'd63, 4'd0, 4'd0));
        step_walker();
        // All-ones cell word at the far corner.
        send(mk_req(KIND_LOAD, 6'd63, 6'd63, 4'hF, 4'hF));
        send(mk_req(KIND_START, 6'd63, 6'd63, 4'd0, 4'd0));

        // Random walks with occasional reloads and noise requests.
        while (n_sent < N_ITEMS) begin
            if (n_sent >= N_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (!paused && n_sent >= N_ITEMS / 2) begin
                // Hold off until everything in flight has been reported.
                wait_drained();
                paused = 1'b1;
                @(posedge i_clk);
            end
            if ($urandom_range(0, 4) != 0) begin
                start_at(pick_coord(), pick_coord(), 1'($urandom));
                steps = $urandom_range(1, 40);
                for (int i = 0; i < steps && walking[GEN_VIEW]; i++) begin
                    if ($urandom_range(0, 14) == 0)
                        send(mk_req(KIND_LOAD, at_row[GEN_VIEW], at_col[GEN_VIEW],
                                    rand_open(), rand_exit()));
                    if ($urandom_range(0, 39) == 0)
                        send(mk_req(KIND_NONE, 6'($urandom), 6'($urandom),
                                    4'($urandom), 4'($urandom)));
                    step_walker();
                end
                if ($urandom_range(0, 3) == 0) step_walker();
            end else begin
                case ($urandom_range(0, 3))
                    0: send(mk_req(KIND_LOAD, 6'($urandom), 6'($urandom),
                                   4'($urandom), 4'($urandom)));
                    1: step_walker();
                    2: send(mk_req(KIND_NONE, 6'($urandom), 6'($urandom),
                                   4'($urandom), 4'($urandom)));
                    default: start_at(pick_coord(), pick_coord(), 1'b1);
                endcase
            end
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (n_bad == 0) begin
            $display("tb_maze_wall_follower_unit: PASS");
        end else begin
            $display("tb_maze_wall_follower_unit: FAIL");
        end
        $finish;
    end

endmodule
